// File: design/assert_macros.svh
// assertion macros shared by the effect slot manager rtl
// no dependencies; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// property holds at every edge outside reset
`define FFBM_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("ffbm assertion failed");
// same-cycle implication
`define FFBM_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("ffbm implication failed");
// next-cycle implication
`define FFBM_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("ffbm next-cycle check failed");
`else
`define FFBM_ASSERT(lbl, clk, rst_n, prop)
`define FFBM_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define FFBM_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// File: design/ffbm_pkg.sv
`timescale 1ns / 1ps
// types and codes of the force-feedback effect slot manager
// used by ffbm_slot_ram, ffbm_seq and ffb_effect_slot_manager
package ffbm_pkg;

	localparam int SLOT_W = 8;

	// request kinds
	localparam logic [2:0] KIND_CREATE = 3'd0;
	localparam logic [2:0] KIND_SETDUR = 3'd1;
	localparam logic [2:0] KIND_OPER   = 3'd2;
	localparam logic [2:0] KIND_FREE   = 3'd3;
	localparam logic [2:0] KIND_CTRL   = 3'd4;
	localparam logic [2:0] KIND_GAIN   = 3'd5;

	// effect operation codes
	localparam logic [7:0] OP_START = 8'h01;
	localparam logic [7:0] OP_SOLO  = 8'h02;
	localparam logic [7:0] OP_STOP  = 8'h03;

	// device control codes
	localparam logic [7:0] CTRL_ENABLE   = 8'h01;
	localparam logic [7:0] CTRL_DISABLE  = 8'h02;
	localparam logic [7:0] CTRL_STOP_ALL = 8'h03;
	localparam logic [7:0] CTRL_RESET    = 8'h04;
	localparam logic [7:0] CTRL_PAUSE    = 8'h05;
	localparam logic [7:0] CTRL_CONTINUE = 8'h06;

	localparam logic [7:0] FREE_ALL      = 8'hFF;
	localparam logic [7:0] LOOP_INFINITE = 8'hFF;

	localparam logic [1:0] FLAG_ALLOC = 2'b01;
	localparam logic [1:0] FLAG_PLAY  = 2'b10;

	typedef struct packed {
		logic [2:0]        kind;
		logic [SLOT_W-1:0] slot_index;
		logic [7:0]        command_code;
		logic [7:0]        loop_count;
		logic [15:0]       duration_value;
		logic [7:0]        gain_value;
	} item_t;

	typedef struct packed {
		logic [7:0]  block_index;
		logic        load_status;
		logic [15:0] pool_available;
		logic        actuators_enabled;
		logic        device_paused;
		logic [7:0]  device_gain;
		logic        slot_playing;
		logic [15:0] slot_duration;
	} res_t;

	// slot store access, one read and one write address per cycle
	typedef struct packed {
		logic              rd_en;
		logic [SLOT_W-1:0] rd_addr;
		logic [SLOT_W-1:0] wr_addr;
		logic              flag_we;
		logic [1:0]        flag_wdata;
		logic              len_we;
		logic [15:0]       len_wdata;
	} ram_req_t;

	typedef struct packed {
		logic [1:0]  flags;
		logic [15:0] len;
	} ram_rsp_t;

endpackage

// File: design/ffbm_slot_ram.sv
`timescale 1ns / 1ps
// slot store: flag and duration memories with registered read data
// depends on ffbm_pkg
module ffbm_slot_ram import ffbm_pkg::*; #(
	parameter int MAX_SLOTS = 15
) (
	input  logic     clk,
	input  ram_req_t req,
	output ram_rsp_t rsp
);

	localparam int SLOT_COUNT = MAX_SLOTS + 1;
	localparam int IDX_W = $clog2(SLOT_COUNT);

	logic [1:0]  flag_mem [SLOT_COUNT];
	logic [15:0] len_mem  [SLOT_COUNT];
	ram_rsp_t    rsp_q;

	always_ff @(posedge clk) begin
		if (req.flag_we) begin
			flag_mem[req.wr_addr[IDX_W-1:0]] <= req.flag_wdata;
		end
		if (req.len_we) begin
			len_mem[req.wr_addr[IDX_W-1:0]] <= req.len_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rsp_q.flags <= flag_mem[req.rd_addr[IDX_W-1:0]];
			rsp_q.len   <= len_mem[req.rd_addr[IDX_W-1:0]];
		end
	end

	assign rsp = rsp_q;

endmodule

// File: design/ffbm_seq.sv
`timescale 1ns / 1ps
// request sequencer: decodes one request, walks the slot store, builds the status word
// depends on ffbm_pkg, ffbm_slot_ram and assert_macros.svh
`include "assert_macros.svh"
module ffbm_seq import ffbm_pkg::*; #(
	parameter int MAX_SLOTS  = 15,
	parameter int POOL_BYTES = 4096,
	parameter int SLOT_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  item_t       item,
	input  logic [15:0] infinite_duration,
	output logic        res_valid,
	input  logic        res_ready,
	output res_t        res
);

	localparam logic [SLOT_W-1:0] MAX_IDX = SLOT_W'(MAX_SLOTS);
	localparam logic [15:0] POOL16 = 16'(POOL_BYTES);
	localparam logic [15:0] SLOT16 = 16'(SLOT_BYTES);

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_EXEC, S_SEARCH, S_SEARCH_CHK, S_STOP, S_STOP_LAST,
		S_RMW_RD, S_RMW_WR, S_FETCH, S_REPORT
	} state_t;

	typedef enum logic [1:0] {
		RMW_START, RMW_SETPLAY, RMW_CLRPLAY
	} rmw_t;

	state_t            state_q;
	rmw_t              mode_q;
	logic              init_q;
	item_t             item_q;
	logic [SLOT_W-1:0] hint_q;
	logic [15:0]       pool_q;
	logic [7:0]        last_index_q;
	logic              last_status_q;
	logic              enable_q;
	logic              pause_q;
	logic [7:0]        gain_q;
	logic [SLOT_W-1:0] ptr_q;
	logic [SLOT_W-1:0] wr_ptr_s1;
	logic              wr_vld_s1;

	ram_req_t ram_req;
	ram_rsp_t ram_rsp;

	logic        accept;
	logic        in_range;
	logic [23:0] prod;
	logic [15:0] start_len;
	logic [16:0] pool_up;
	logic [15:0] pool_inc;
	logic [15:0] pool_dec;
	state_t      after_stop;

	ffbm_slot_ram #(
		.MAX_SLOTS(MAX_SLOTS)
	) u_ram (
		.clk(clk),
		.req(ram_req),
		.rsp(ram_rsp)
	);

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign in_range   = (item_q.slot_index <= MAX_IDX);

	// start: multiply by a nonzero loop count, load the infinite duration, or keep the length
	assign prod = 24'(ram_rsp.len) * 24'(item_q.loop_count);
	always_comb begin
		if (item_q.loop_count == LOOP_INFINITE) begin
			start_len = infinite_duration;
		end else if (item_q.loop_count != 8'd0) begin
			start_len = prod[15:0];
		end else begin
			start_len = ram_rsp.len;
		end
	end

	assign pool_up  = {1'b0, pool_q} + {1'b0, SLOT16};
	assign pool_inc = (pool_up > {1'b0, POOL16}) ? POOL16 : pool_up[15:0];
	assign pool_dec = (pool_q >= SLOT16) ? (pool_q - SLOT16) : 16'd0;

	// solo start sets the playing bit after the stop sweep
	assign after_stop = (item_q.kind == KIND_OPER && in_range) ? S_RMW_RD : S_FETCH;

	always_comb begin
		ram_req = '0;
		case (state_q)
			S_CLEAR: begin
				ram_req.wr_addr = ptr_q;
				ram_req.flag_we = 1'b1;
				ram_req.len_we  = 1'b1;
			end
			S_EXEC: begin
				case (item_q.kind)
					KIND_CREATE: begin
						if (hint_q < MAX_IDX) begin
							ram_req.wr_addr    = hint_q;
							ram_req.flag_we    = 1'b1;
							ram_req.flag_wdata = FLAG_ALLOC;
							ram_req.len_we     = 1'b1;
						end
					end
					KIND_SETDUR: begin
						if (in_range) begin
							ram_req.wr_addr   = item_q.slot_index;
							ram_req.len_we    = 1'b1;
							ram_req.len_wdata = item_q.duration_value;
						end
					end
					KIND_FREE: begin
						if (item_q.slot_index != FREE_ALL && in_range) begin
							ram_req.wr_addr = item_q.slot_index;
							ram_req.flag_we = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
			S_SEARCH: begin
				ram_req.rd_en   = (hint_q < MAX_IDX);
				ram_req.rd_addr = hint_q;
			end
			S_STOP, S_STOP_LAST: begin
				ram_req.rd_en      = (state_q == S_STOP);
				ram_req.rd_addr    = ptr_q;
				ram_req.wr_addr    = wr_ptr_s1;
				ram_req.flag_we    = wr_vld_s1;
				ram_req.flag_wdata = ram_rsp.flags & FLAG_ALLOC;
			end
			S_RMW_RD: begin
				ram_req.rd_en   = 1'b1;
				ram_req.rd_addr = item_q.slot_index;
			end
			S_RMW_WR: begin
				ram_req.wr_addr = item_q.slot_index;
				ram_req.flag_we = 1'b1;
				case (mode_q)
					RMW_START: begin
						ram_req.flag_wdata = ram_rsp.flags | FLAG_PLAY;
						ram_req.len_we     = 1'b1;
						ram_req.len_wdata  = start_len;
					end
					RMW_SETPLAY: ram_req.flag_wdata = ram_rsp.flags | FLAG_PLAY;
					RMW_CLRPLAY: ram_req.flag_wdata = ram_rsp.flags & FLAG_ALLOC;
					default:     ram_req.flag_wdata = ram_rsp.flags;
				endcase
			end
			S_FETCH: begin
				ram_req.rd_en   = in_range;
				ram_req.rd_addr = item_q.slot_index;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			mode_q        <= RMW_START;
			init_q        <= 1'b1;
			hint_q        <= SLOT_W'(1);
			pool_q        <= POOL16;
			last_index_q  <= 8'd0;
			last_status_q <= 1'b0;
			enable_q      <= 1'b0;
			pause_q       <= 1'b0;
			gain_q        <= 8'd0;
			ptr_q         <= '0;
			wr_ptr_s1     <= '0;
			wr_vld_s1     <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (ptr_q == MAX_IDX) begin
						ptr_q   <= '0;
						hint_q  <= SLOT_W'(1);
						pool_q  <= POOL16;
						init_q  <= 1'b0;
						state_q <= init_q ? S_IDLE : S_FETCH;
					end else begin
						ptr_q <= ptr_q + SLOT_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FETCH;
					case (item_q.kind)
						KIND_CREATE: begin
							if (hint_q >= MAX_IDX) begin
								last_index_q  <= 8'd0;
								last_status_q <= 1'b1;
							end else begin
								last_index_q  <= hint_q;
								last_status_q <= 1'b0;
								pool_q        <= pool_dec;
								hint_q        <= hint_q + SLOT_W'(1);
								state_q       <= S_SEARCH;
							end
						end
						KIND_OPER: begin
							case (item_q.command_code)
								OP_START: begin
									mode_q <= RMW_START;
									if (in_range) begin
										state_q <= S_RMW_RD;
									end
								end
								OP_SOLO: begin
									mode_q  <= RMW_SETPLAY;
									ptr_q   <= '0;
									state_q <= S_STOP;
								end
								OP_STOP: begin
									mode_q <= RMW_CLRPLAY;
									if (in_range) begin
										state_q <= S_RMW_RD;
									end
								end
								default: begin
								end
							endcase
						end
						KIND_FREE: begin
							if (item_q.slot_index == FREE_ALL) begin
								ptr_q   <= '0;
								state_q <= S_CLEAR;
							end else if (in_range) begin
								pool_q <= pool_inc;
								if (item_q.slot_index < hint_q) begin
									hint_q <= (item_q.slot_index == '0) ? SLOT_W'(1)
										: item_q.slot_index;
								end
							end
						end
						KIND_CTRL: begin
							case (item_q.command_code)
								CTRL_ENABLE:   enable_q <= 1'b1;
								CTRL_DISABLE:  enable_q <= 1'b0;
								CTRL_STOP_ALL: begin
									ptr_q   <= '0;
									state_q <= S_STOP;
								end
								CTRL_RESET: begin
									ptr_q   <= '0;
									state_q <= S_CLEAR;
								end
								CTRL_PAUSE:    pause_q <= 1'b1;
								CTRL_CONTINUE: pause_q <= 1'b0;
								default: begin
								end
							endcase
						end
						KIND_GAIN: gain_q <= item_q.gain_value;
						default: begin
						end
					endcase
				end
				S_SEARCH: begin
					state_q <= (hint_q >= MAX_IDX) ? S_FETCH : S_SEARCH_CHK;
				end
				S_SEARCH_CHK: begin
					if (ram_rsp.flags != 2'b00) begin
						hint_q  <= hint_q + SLOT_W'(1);
						state_q <= S_SEARCH;
					end else begin
						state_q <= S_FETCH;
					end
				end
				S_STOP: begin
					// read slot ptr now, write it back in the next cycle
					wr_ptr_s1 <= ptr_q;
					wr_vld_s1 <= 1'b1;
					if (ptr_q == MAX_IDX) begin
						state_q <= S_STOP_LAST;
					end else begin
						ptr_q <= ptr_q + SLOT_W'(1);
					end
				end
				S_STOP_LAST: begin
					wr_vld_s1 <= 1'b0;
					ptr_q     <= '0;
					state_q   <= after_stop;
				end
				S_RMW_RD: state_q <= S_RMW_WR;
				S_RMW_WR: state_q <= S_FETCH;
				S_FETCH:  state_q <= S_REPORT;
				S_REPORT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = (state_q == S_REPORT);

	always_comb begin
		res.block_index       = last_index_q;
		res.load_status       = last_status_q;
		res.pool_available    = pool_q;
		res.actuators_enabled = enable_q;
		res.device_paused     = pause_q;
		res.device_gain       = gain_q;
		res.slot_playing      = in_range ? ram_rsp.flags[1] : 1'b0;
		res.slot_duration     = in_range ? ram_rsp.len : 16'd0;
	end

	`FFBM_ASSERT(a_pool_bound, clk, arst_n, pool_q <= POOL16)
	`FFBM_ASSERT(a_hint_range, clk, arst_n, hint_q != '0 && hint_q <= MAX_IDX)
	`FFBM_ASSERT_IMPL(a_sweep_no_overlap, clk, arst_n, ram_req.rd_en && ram_req.flag_we, ram_req.rd_addr != ram_req.wr_addr)
	`FFBM_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == S_EXEC)
	`FFBM_ASSERT_NEXT(a_create_hint, clk, arst_n, state_q == S_EXEC && item_q.kind == KIND_CREATE && hint_q < MAX_IDX, hint_q == $past(hint_q) + SLOT_W'(1))

endmodule

// File: design/ffb_effect_slot_manager.sv
`timescale 1ns / 1ps
// Force-feedback effect slot manager: one request word in, one status word out, one request
// at a time. The free-slot search after a create skips occupied slots. The slot store has a
// single read and a single write port, so some requests walk it once: stop all, solo start,
// free all and reset. After reset a clearing pass runs before the first request is taken. A
// finished status word waits in the output register, and the next request can be accepted
// in the cycle after the word moves there. Depends on ffbm_pkg and ffbm_seq.
module ffb_effect_slot_manager import ffbm_pkg::*; #(
	parameter int MAX_SLOTS  = 15,
	parameter int POOL_BYTES = 4096,
	parameter int SLOT_BYTES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot_index, command_code, loop_count, duration_value, gain_value
	input  logic [47:0] s_tdata,
	// kind
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// block_index, load_status, pool_available, actuators_enabled,
	// device_paused, device_gain, slot_playing, slot_duration, 4 zero bits
	output logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	item_t       item;
	res_t        res;
	logic        res_valid;
	logic        res_ready;
	logic [15:0] inf_dur_q;
	logic        out_valid_q;
	res_t        out_word_q;

	assign item.kind           = s_tuser;
	assign item.slot_index     = s_tdata[7:0];
	assign item.command_code   = s_tdata[15:8];
	assign item.loop_count     = s_tdata[23:16];
	assign item.duration_value = s_tdata[39:24];
	assign item.gain_value     = s_tdata[47:40];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inf_dur_q <= 16'hFFFF;
		end else if (cfg_we) begin
			inf_dur_q <= cfg_wdata;
		end
	end

	ffbm_seq #(
		.MAX_SLOTS(MAX_SLOTS),
		.POOL_BYTES(POOL_BYTES),
		.SLOT_BYTES(SLOT_BYTES)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(s_tvalid),
		.item_ready(s_tready),
		.item(item),
		.infinite_duration(inf_dur_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	// output register, refilled as it drains
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_word_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0,
		out_word_q.slot_duration,
		out_word_q.slot_playing,
		out_word_q.device_gain,
		out_word_q.device_paused,
		out_word_q.actuators_enabled,
		out_word_q.pool_available,
		out_word_q.load_status,
		out_word_q.block_index};

endmodule

// File: sim/tb_ffb_effect_slot_manager.sv
`timescale 1ns / 1ps
// self-checking bench for ffb_effect_slot_manager: directed table, then random requests
// scored against an in-bench slot table model; depends on ffbm_pkg and the block rtl
module tb_ffb_effect_slot_manager;
	import ffbm_pkg::*;

	localparam int MAX_SLOTS  = 15;
	localparam int POOL_BYTES = 4096;
	localparam int SLOT_BYTES = 64;

	// kinds the block must ignore
	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;

	localparam int PHASE_ITEMS = 85;
	localparam int END_CYCLES  = 2 * MAX_SLOTS + 10;
	localparam int QUIET_LIMIT = 1000;

	typedef struct {
		item_t it;
		int    reps;
		bit    typed;
		res_t  want;
	} plan_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;   // slot_index, command_code, loop_count, duration_value, gain_value
	logic [2:0]  s_tuser;   // kind
	logic        m_tvalid;
	logic        m_tready;
	logic [55:0] m_tdata;   // block_index, load_status, pool_available, actuators_enabled,
	                        // device_paused, device_gain, slot_playing, slot_duration
	logic        cfg_we;
	logic [15:0] cfg_wdata;

	// slot table model state
	logic [1:0]  slot_flag [0:MAX_SLOTS];
	logic [15:0] slot_len [0:MAX_SLOTS];
	int unsigned hint;
	int unsigned pool_left;
	logic [7:0]  last_block;
	logic        last_full;
	logic        act_en;
	logic        paused;
	logic [7:0]  gain_now;
	logic [15:0] inf_len;

	res_t        status_due [$];
	plan_row_t   plan [$];
	int          fail_count;
	int          quiet_cycles;
	bit          idling_on;

	ffb_effect_slot_manager #(
		.MAX_SLOTS(MAX_SLOTS),
		.POOL_BYTES(POOL_BYTES),
		.SLOT_BYTES(SLOT_BYTES)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic void wipe_slots();
		for (int i = 0; i <= MAX_SLOTS; i++) begin
			slot_flag[i] = 2'b00;
			slot_len[i] = 16'h0;
		end
		hint = 1;
		pool_left = POOL_BYTES;
	endfunction

	function automatic void halt_all();
		for (int i = 0; i <= MAX_SLOTS; i++)
			slot_flag[i] = slot_flag[i] & ~FLAG_PLAY;
	endfunction

	// advance the slot table by one request and return the status word it produces
	function automatic res_t apply_request(item_t it);
		res_t        r;
		int unsigned id;
		int unsigned found;
		logic [23:0] prod;
		id = it.slot_index;
		case (it.kind)
			KIND_CREATE: begin
				if (hint >= MAX_SLOTS) begin
					last_block = 8'd0;
					last_full = 1'b1;
				end else begin
					found = hint;
					hint++;
					while (hint < MAX_SLOTS && slot_flag[hint] != 2'b00)
						hint++;
					slot_flag[found] = FLAG_ALLOC;
					slot_len[found] = 16'h0;
					pool_left = (pool_left >= SLOT_BYTES) ? pool_left - SLOT_BYTES : 0;
					last_block = found[7:0];
					last_full = 1'b0;
				end
			end
			KIND_SETDUR: begin
				if (id <= MAX_SLOTS)
					slot_len[id] = it.duration_value;
			end
			KIND_OPER: begin
				if (it.command_code == OP_START) begin
					if (id <= MAX_SLOTS) begin
						if (it.loop_count != 8'd0) begin
							prod = slot_len[id] * it.loop_count;
							slot_len[id] = prod[15:0];
						end
						if (it.loop_count == LOOP_INFINITE)
							slot_len[id] = inf_len;
						slot_flag[id] = slot_flag[id] | FLAG_PLAY;
					end
				end else if (it.command_code == OP_SOLO) begin
					halt_all();
					if (id <= MAX_SLOTS)
						slot_flag[id] = slot_flag[id] | FLAG_PLAY;
				end else if (it.command_code == OP_STOP) begin
					if (id <= MAX_SLOTS)
						slot_flag[id] = slot_flag[id] & ~FLAG_PLAY;
				end
			end
			KIND_FREE: begin
				if (it.slot_index == FREE_ALL) begin
					wipe_slots();
				end else if (id <= MAX_SLOTS) begin
					slot_flag[id] = 2'b00;
					if (id < hint)
						hint = (id < 1) ? 1 : id;
					pool_left = (pool_left + SLOT_BYTES > POOL_BYTES) ?
						POOL_BYTES : pool_left + SLOT_BYTES;
				end
			end
			KIND_CTRL: begin
				case (it.command_code)
					CTRL_ENABLE:   act_en = 1'b1;
					CTRL_DISABLE:  act_en = 1'b0;
					CTRL_STOP_ALL: halt_all();
					CTRL_RESET:    wipe_slots();
					CTRL_PAUSE:    paused = 1'b1;
					CTRL_CONTINUE: paused = 1'b0;
					default: ;
				endcase
			end
			KIND_GAIN: gain_now = it.gain_value;
			default: ;
		endcase
		r.block_index = last_block;
		r.load_status = last_full;
		r.pool_available = pool_left[15:0];
		r.actuators_enabled = act_en;
		r.device_paused = paused;
		r.device_gain = gain_now;
		if (id <= MAX_SLOTS) begin
			r.slot_playing = slot_flag[id][1];
			r.slot_duration = slot_len[id];
		end else begin
			r.slot_playing = 1'b0;
			r.slot_duration = 16'h0;
		end
		return r;
	endfunction

	function automatic plan_row_t req(logic [2:0] kind, int idx, int code, int loops,
			int dur, int gain);
		plan_row_t p;
		p.it.kind = kind;
		p.it.slot_index = idx[7:0];
		p.it.command_code = code[7:0];
		p.it.loop_count = loops[7:0];
		p.it.duration_value = dur[15:0];
		p.it.gain_value = gain[7:0];
		p.reps = 1;
		p.typed = 1'b0;
		p.want = '0;
		return p;
	endfunction

	function automatic plan_row_t checked(plan_row_t p, res_t want);
		p.typed = 1'b1;
		p.want = want;
		return p;
	endfunction

	// mostly well-formed traffic aimed at live slots, with some noise mixed in
	function automatic item_t random_request();
		item_t       it;
		int unsigned r;
		int unsigned pick;
		it.kind = KIND_GAIN;
		it.slot_index = 8'($urandom);
		it.command_code = 8'($urandom);
		it.loop_count = 8'($urandom);
		it.duration_value = 16'($urandom);
		it.gain_value = 8'($urandom);
		r = $urandom_range(0, 99);
		if (r < 22)
			it.kind = KIND_CREATE;
		else if (r < 40)
			it.kind = KIND_SETDUR;
		else if (r < 65)
			it.kind = KIND_OPER;
		else if (r < 77)
			it.kind = KIND_FREE;
		else if (r < 87)
			it.kind = KIND_CTRL;
		else if (r < 95)
			it.kind = KIND_GAIN;
		else
			it.kind = r[0] ? KIND_RSVD7 : KIND_RSVD6;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			it.slot_index = last_block;
		else if (pick < 8)
			it.slot_index = 8'($urandom_range(0, MAX_SLOTS));
		else if (pick == 9)
			it.slot_index = FREE_ALL;
		if (it.kind == KIND_OPER) begin
			pick = $urandom_range(0, 9);
			if (pick < 4)
				it.command_code = OP_START;
			else if (pick < 6)
				it.command_code = OP_SOLO;
			else if (pick < 9)
				it.command_code = OP_STOP;
			case ($urandom_range(0, 5))
				0: it.loop_count = 8'd0;
				1: it.loop_count = 8'd1;
				2: it.loop_count = 8'd2;
				3: it.loop_count = LOOP_INFINITE;
				4: it.loop_count = 8'($urandom_range(3, 9));
				default: ;
			endcase
		end else if (it.kind == KIND_SETDUR) begin
			if ($urandom_range(0, 1) == 0)
				it.duration_value = 16'($urandom_range(0, 15));
		end else if (it.kind == KIND_CTRL) begin
			case ($urandom_range(0, 19))
				0: it.command_code = CTRL_RESET;
				1: ;
				2, 3, 4, 5: it.command_code = CTRL_ENABLE;
				6, 7, 8: it.command_code = CTRL_DISABLE;
				9, 10, 11, 12: it.command_code = CTRL_STOP_ALL;
				13, 14, 15: it.command_code = CTRL_PAUSE;
				default: it.command_code = CTRL_CONTINUE;
			endcase
		end
		return it;
	endfunction

	task automatic issue(item_t it, bit typed, res_t want);
		res_t got;
		s_tvalid <= 1'b1;
		s_tuser <= it.kind;
		s_tdata <= {it.gain_value, it.duration_value, it.loop_count, it.command_code,
			it.slot_index};
		do @(posedge clk); while (!s_tready);
		got = apply_request(it);
		status_due.push_back(typed ? want : got);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
	endtask

	task automatic set_infinite(logic [15:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		inf_len = v;
	endtask

	task automatic compare_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin : score
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (status_due.size() == 0) begin
				$error("status word with none outstanding: 0x%0h", m_tdata);
				fail_count++;
			end else begin
				want = status_due.pop_front();
				compare_field("block_index", want.block_index, m_tdata[7:0]);
				compare_field("load_status", want.load_status, m_tdata[8]);
				compare_field("pool_available", want.pool_available, m_tdata[24:9]);
				compare_field("actuators_enabled", want.actuators_enabled, m_tdata[25]);
				compare_field("device_paused", want.device_paused, m_tdata[26]);
				compare_field("device_gain", want.device_gain, m_tdata[34:27]);
				compare_field("slot_playing", want.slot_playing, m_tdata[35]);
				compare_field("slot_duration", want.slot_duration, m_tdata[51:36]);
			end
		end
	end

	// hang detector: cycles with no word moving on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// result side backpressure
	initial begin
		@(posedge arst_n);
		forever begin
			if (idling_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	initial begin
		logic [15:0] setting;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		fail_count = 0;
		quiet_cycles = 0;
		idling_on = 1'b1;
		wipe_slots();
		last_block = 8'd0;
		last_full = 1'b0;
		act_en = 1'b0;
		paused = 1'b0;
		gain_now = 8'd0;
		inf_len = 16'hFFFF;

		plan.push_back(checked(req(KIND_GAIN, 0, 0, 0, 0, 8'hFF),
			res_t'{8'd0, 1'b0, 16'd4096, 1'b0, 1'b0, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(checked(req(KIND_CTRL, 0, CTRL_ENABLE, 0, 0, 0),
			res_t'{8'd0, 1'b0, 16'd4096, 1'b1, 1'b0, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(checked(req(KIND_CTRL, 0, CTRL_PAUSE, 0, 0, 0),
			res_t'{8'd0, 1'b0, 16'd4096, 1'b1, 1'b1, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(checked(req(KIND_CREATE, 1, 0, 0, 0, 0),
			res_t'{8'd1, 1'b0, 16'd4032, 1'b1, 1'b1, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(checked(req(KIND_SETDUR, 1, 0, 0, 16'hFFFF, 0),
			res_t'{8'd1, 1'b0, 16'd4032, 1'b1, 1'b1, 8'hFF, 1'b0, 16'hFFFF}));
		// duration times loop count wraps
		plan.push_back(checked(req(KIND_OPER, 1, OP_START, 2, 0, 0),
			res_t'{8'd1, 1'b0, 16'd4032, 1'b1, 1'b1, 8'hFF, 1'b1, 16'hFFFE}));
		plan.push_back(checked(req(KIND_OPER, 1, OP_START, LOOP_INFINITE, 0, 0),
			res_t'{8'd1, 1'b0, 16'd4032, 1'b1, 1'b1, 8'hFF, 1'b1, 16'hFFFF}));
		plan.push_back(req(KIND_OPER, 1, OP_START, 0, 0, 0));
		plan.push_back(req(KIND_SETDUR, 0, 0, 0, 16'h1234, 0));
		plan.push_back(req(KIND_OPER, 0, OP_SOLO, 3, 0, 0));
		plan.push_back(req(KIND_OPER, 1, OP_STOP, 0, 0, 0));
		plan.push_back(req(KIND_OPER, MAX_SLOTS, OP_START, 1, 0, 0));
		// solo start on a missing slot still stops everything
		plan.push_back(checked(req(KIND_OPER, 200, OP_SOLO, 1, 0, 0),
			res_t'{8'd1, 1'b0, 16'd4032, 1'b1, 1'b1, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(checked(req(KIND_SETDUR, MAX_SLOTS + 1, 0, 0, 16'hFFFF, 0),
			res_t'{8'd1, 1'b0, 16'd4032, 1'b1, 1'b1, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(req(KIND_OPER, 1, 0, 5, 0, 0));
		plan.push_back(req(KIND_OPER, 0, 8'hFF, 5, 0, 0));
		plan.push_back(req(KIND_CTRL, MAX_SLOTS, CTRL_STOP_ALL, 0, 0, 0));
		plan.push_back(req(KIND_CREATE, 0, 0, 0, 0, 0));
		plan[$].reps = MAX_SLOTS - 2;
		// every handed-out slot is taken now
		plan.push_back(checked(req(KIND_CREATE, 255, 0, 0, 0, 0),
			res_t'{8'd0, 1'b1, 16'd3200, 1'b1, 1'b1, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(req(KIND_FREE, 0, 0, 0, 0, 0));
		plan.push_back(req(KIND_CREATE, 1, 0, 0, 0, 0));
		plan.push_back(checked(req(KIND_FREE, FREE_ALL, 0, 0, 0, 0),
			res_t'{8'd1, 1'b0, 16'd4096, 1'b1, 1'b1, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(req(KIND_CTRL, 2, CTRL_RESET, 0, 0, 0));
		plan.push_back(req(KIND_CTRL, 0, CTRL_DISABLE, 0, 0, 0));
		plan.push_back(checked(req(KIND_CTRL, 0, CTRL_CONTINUE, 0, 0, 0),
			res_t'{8'd1, 1'b0, 16'd4096, 1'b0, 1'b0, 8'hFF, 1'b0, 16'h0}));
		plan.push_back(req(KIND_CTRL, 0, 0, 0, 0, 0));
		plan.push_back(req(KIND_CTRL, 0, 8'hFF, 0, 0, 0));
		plan.push_back(req(KIND_RSVD6, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'hFF));
		plan.push_back(req(KIND_RSVD7, 1, CTRL_RESET, 8'hFF, 16'hFFFF, 8'h00));
		plan.push_back(req(KIND_GAIN, 0, 0, 0, 0, 0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			for (int n = 0; n < plan[i].reps; n++)
				issue(plan[i].it, plan[i].typed, plan[i].want);

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: setting = 16'h0000;
				1: setting = 16'hFFFF;
				3: setting = 16'h0001;
				default: setting = 16'($urandom);
			endcase
			// last stretch runs at full rate on both sides
			if (ph == 4)
				idling_on = 1'b0;
			set_infinite(setting);
			repeat (PHASE_ITEMS)
				issue(random_request(), 1'b0, '0);
		end

		settle();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
